// ===== rtl/mra_pkg.sv =====
// ----------------------------------------------------------------------------
// mra_pkg
// Shared sizes, codes and types of the multi-class resource allocator.
// ----------------------------------------------------------------------------
package mra_pkg;

	localparam int NUM_CLASSES    = 8;
	localparam int NUM_CLIENTS    = 32;
	localparam int INSTANCES      = 15;
	localparam int WAIT_DEPTH     = 32;
	localparam int PACKED_CLASSES = 8;

	localparam int FUNC_W   = 2;
	localparam int CLIENT_W = 5;
	localparam int AMT_W    = 32;
	localparam int KIND_W   = 2;
	localparam int CNT_W    = 4;

	localparam int CID_W   = $clog2(NUM_CLIENTS);
	localparam int WADDR_W = $clog2(WAIT_DEPTH);
	localparam int WLEN_W  = WADDR_W + 1;
	localparam int ENTRY_W = CLIENT_W + AMT_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_REQUEST   = 2'd0,
		FUNC_RELEASE   = 2'd1,
		FUNC_TERMINATE = 2'd2
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_GRANTED    = 2'd0,
		KIND_QUEUED     = 2'd1,
		KIND_RELEASED   = 2'd2,
		KIND_TERMINATED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		POOL_NONE,
		POOL_GRANT,
		POOL_RELEASE,
		POOL_TERMINATE
	} pool_op_t;

	typedef struct packed {
		pool_op_t           op;
		logic [CID_W-1:0]   who;
		logic [AMT_W-1:0]   amounts;
	} pool_ctl_t;

endpackage

// ===== rtl/mra_req_if.sv =====
// ----------------------------------------------------------------------------
// mra_req_if
// Command channel: valid/ready handshake with function, client and counts.
// ----------------------------------------------------------------------------
interface mra_req_if import mra_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [CLIENT_W-1:0] client;
	logic [AMT_W-1:0]    amounts;

	modport source (output valid, output func, output client, output amounts, input ready);
	modport sink   (input valid, input func, input client, input amounts, output ready);

endinterface

// ===== rtl/mra_res_if.sv =====
// ----------------------------------------------------------------------------
// mra_res_if
// Result channel: valid/ready handshake with kind, target client and last.
// ----------------------------------------------------------------------------
interface mra_res_if import mra_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [CLIENT_W-1:0] target;
	logic                last;

	modport source (output valid, output kind, output target, output last, input ready);
	modport sink   (input valid, input kind, input target, input last, output ready);

endinterface

// ===== rtl/mra_lane.sv =====
// ----------------------------------------------------------------------------
// mra_lane
// One resource class: fit check, grant and clamped release of one count.
// ----------------------------------------------------------------------------
module mra_lane import mra_pkg::*; (
	input  logic [CNT_W-1:0] avail,
	input  logic [CNT_W-1:0] held,
	input  logic [CNT_W-1:0] amt,
	input  pool_op_t         op,
	output logic             fit,
	output logic [CNT_W-1:0] avail_nxt,
	output logic [CNT_W-1:0] held_nxt
);

	logic [CNT_W-1:0] give_back;

	assign fit = (amt <= avail);

	always_comb begin
		// clamp the returned count to what the client holds
		if (op == POOL_TERMINATE || amt > held) begin
			give_back = held;
		end else begin
			give_back = amt;
		end
		case (op)
			POOL_GRANT: begin
				avail_nxt = avail - amt;
				held_nxt  = held + amt;
			end
			POOL_RELEASE, POOL_TERMINATE: begin
				avail_nxt = avail + give_back;
				held_nxt  = held - give_back;
			end
			default: begin
				avail_nxt = avail;
				held_nxt  = held;
			end
		endcase
	end

endmodule

// ===== rtl/mra_pool.sv =====
// ----------------------------------------------------------------------------
// mra_pool
// Available counts and per-client held table, one lane per class, merged fit.
// ----------------------------------------------------------------------------
module mra_pool import mra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pool_ctl_t ctl,
	output logic      fit
);

	logic [CNT_W-1:0]       avail_q [NUM_CLASSES];
	logic [CNT_W-1:0]       held_q  [NUM_CLIENTS][NUM_CLASSES];
	logic [CNT_W-1:0]       amt       [NUM_CLASSES];
	logic [CNT_W-1:0]       avail_nxt [NUM_CLASSES];
	logic [CNT_W-1:0]       held_nxt  [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] lane_fit;

	for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
		if (c < PACKED_CLASSES) begin : g_packed
			assign amt[c] = ctl.amounts[CNT_W*c +: CNT_W];
		end else begin : g_zero
			assign amt[c] = '0;
		end

		mra_lane u_lane (
			.avail     (avail_q[c]),
			.held      (held_q[ctl.who][c]),
			.amt       (amt[c]),
			.op        (ctl.op),
			.fit       (lane_fit[c]),
			.avail_nxt (avail_nxt[c]),
			.held_nxt  (held_nxt[c])
		);
	end

	// merge: the item fits only if every class fits
	assign fit = &lane_fit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				avail_q[c] <= CNT_W'(INSTANCES);
			end
			held_q <= '{default: '{default: '0}};
		end else if (ctl.op != POOL_NONE) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				avail_q[c]         <= avail_nxt[c];
				held_q[ctl.who][c] <= held_nxt[c];
			end
		end
	end

endmodule

// ===== rtl/mra_wait_ram.sv =====
// ----------------------------------------------------------------------------
// mra_wait_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mra_wait_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 37
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/multi_resource_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// multi_resource_allocator_unit
// Request: the command is captured, handled in the EXEC state and its result
// loaded into the output register; a new command is taken only back in IDLE.
// Release/terminate: the wait queue scan reads one entry per cycle through the
// single RAM read port, stalled while a granted entry finds the output full.
// Async reset: every class full, nothing held, wait queue empty, no result pending.
// ----------------------------------------------------------------------------
module multi_resource_allocator_unit import mra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	mra_req_if.sink   req,
	mra_res_if.source res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

	state_t state_q;

	// captured command
	logic [FUNC_W-1:0]   cmd_func_q;
	logic [CLIENT_W-1:0] cmd_client_q;
	logic [AMT_W-1:0]    cmd_amounts_q;

	// wait queue bookkeeping
	logic [WLEN_W-1:0] wait_len_q;
	logic [WLEN_W-1:0] rd_ptr_q;
	logic [WLEN_W-1:0] keep_q;
	logic              ent_vld_s1;

	// result held back until we know whether it is the last of its command
	kind_t               pend_kind_q;
	logic [CLIENT_W-1:0] pend_target_q;

	// output register
	logic                res_valid_q;
	kind_t               res_kind_q;
	logic [CLIENT_W-1:0] res_target_q;
	logic                res_last_q;

	// RAM ports
	logic               ram_wr_en;
	logic [WADDR_W-1:0] ram_wr_addr;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic               ram_rd_en;
	logic [ENTRY_W-1:0] ram_rd_data;

	logic [CLIENT_W-1:0] ent_client;
	logic [AMT_W-1:0]    ent_amounts;

	pool_ctl_t pool_ctl;
	logic      fit;

	logic                out_free;
	logic                cmd_is_req;
	kind_t               ack_kind;
	logic                in_ok;
	logic                push;
	kind_t               push_kind;
	logic [CLIENT_W-1:0] push_target;
	logic                push_last;
	logic                ent_grant;
	logic                ent_keep;
	logic                scan_adv;
	logic                scan_done;
	logic                enqueue;

	assign ent_client  = ram_rd_data[ENTRY_W-1:AMT_W];
	assign ent_amounts = ram_rd_data[AMT_W-1:0];

	// the output slot can take a new beat when it is empty or being drained
	assign out_free   = !res_valid_q || res.ready;
	assign cmd_is_req = (cmd_func_q == FUNC_REQUEST);
	assign ack_kind   = (cmd_func_q == FUNC_RELEASE) ? KIND_RELEASED : KIND_TERMINATED;

	// commands with an unused function code or a client out of range are dropped
	assign in_ok = (req.func == FUNC_REQUEST || req.func == FUNC_RELEASE ||
		req.func == FUNC_TERMINATE) && (int'(req.client) < NUM_CLIENTS);

	assign req.ready  = (state_q == ST_IDLE);
	assign res.valid  = res_valid_q;
	assign res.kind   = res_kind_q;
	assign res.target = res_target_q;
	assign res.last   = res_last_q;

	always_comb begin
		pool_ctl.op      = POOL_NONE;
		pool_ctl.who     = CID_W'(cmd_client_q);
		pool_ctl.amounts = cmd_amounts_q;
		ram_wr_en        = 1'b0;
		ram_wr_addr      = keep_q[WADDR_W-1:0];
		ram_wr_data      = ram_rd_data;
		ram_rd_en        = 1'b0;
		push             = 1'b0;
		push_kind        = pend_kind_q;
		push_target      = pend_target_q;
		push_last        = 1'b0;
		ent_grant        = 1'b0;
		ent_keep         = 1'b0;
		scan_adv         = 1'b0;
		scan_done        = 1'b0;
		enqueue          = 1'b0;

		case (state_q)
			ST_EXEC: begin
				// work on the command only when its first beat has a place to go
				if (out_free) begin
					if (cmd_is_req) begin
						push        = 1'b1;
						push_target = cmd_client_q;
						push_last   = 1'b1;
						if (fit) begin
							pool_ctl.op = POOL_GRANT;
							push_kind   = KIND_GRANTED;
						end else begin
							// a full queue drops the entry but still reports queued
							push_kind = KIND_QUEUED;
							if (wait_len_q < WLEN_W'(WAIT_DEPTH)) begin
								enqueue     = 1'b1;
								ram_wr_en   = 1'b1;
								ram_wr_addr = wait_len_q[WADDR_W-1:0];
								ram_wr_data = {cmd_client_q, cmd_amounts_q};
							end
						end
					end else begin
						pool_ctl.op = (cmd_func_q == FUNC_RELEASE) ? POOL_RELEASE :
							POOL_TERMINATE;
						if (wait_len_q == '0) begin
							// nothing waits: the acknowledgement closes the command
							push        = 1'b1;
							push_kind   = ack_kind;
							push_target = cmd_client_q;
							push_last   = 1'b1;
						end else begin
							// prime the scan with the head entry
							ram_rd_en = 1'b1;
						end
					end
				end
			end
			ST_SCAN: begin
				pool_ctl.who     = CID_W'(ent_client);
				pool_ctl.amounts = ent_amounts;
				// hold the entry in place when it is granted but the output is full
				scan_adv = !(ent_vld_s1 && fit && !out_free);
				if (ent_vld_s1 && scan_adv) begin
					if (fit) begin
						ent_grant   = 1'b1;
						pool_ctl.op = POOL_GRANT;
						push        = 1'b1;
					end else begin
						// compact: survivors move down to the keep pointer
						ent_keep  = 1'b1;
						ram_wr_en = 1'b1;
					end
				end
				if (scan_adv && rd_ptr_q < wait_len_q) begin
					ram_rd_en = 1'b1;
				end
				if (!ent_vld_s1 && out_free) begin
					// flush the held-back beat as the last one
					scan_done = 1'b1;
					push      = 1'b1;
					push_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_func_q    <= '0;
			cmd_client_q  <= '0;
			cmd_amounts_q <= '0;
			wait_len_q    <= '0;
			rd_ptr_q      <= '0;
			keep_q        <= '0;
			ent_vld_s1    <= 1'b0;
			pend_kind_q   <= KIND_GRANTED;
			pend_target_q <= '0;
			res_valid_q   <= 1'b0;
			res_kind_q    <= KIND_GRANTED;
			res_target_q  <= '0;
			res_last_q    <= 1'b0;
		end else begin
			// output register: load a beat or drain the taken one
			if (push) begin
				res_valid_q  <= 1'b1;
				res_kind_q   <= push_kind;
				res_target_q <= push_target;
				res_last_q   <= push_last;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (enqueue) begin
				wait_len_q <= wait_len_q + 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					rd_ptr_q <= '0;
					keep_q   <= '0;
					if (req.valid) begin
						cmd_func_q    <= req.func;
						cmd_client_q  <= req.client;
						cmd_amounts_q <= req.amounts;
						if (in_ok) begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (!cmd_is_req && wait_len_q != '0) begin
							pend_kind_q   <= ack_kind;
							pend_target_q <= cmd_client_q;
							rd_ptr_q      <= rd_ptr_q + 1'b1;
							ent_vld_s1    <= 1'b1;
							state_q       <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (ent_grant) begin
						pend_kind_q   <= KIND_GRANTED;
						pend_target_q <= ent_client;
					end
					if (ent_keep) begin
						keep_q <= keep_q + 1'b1;
					end
					if (scan_adv) begin
						if (rd_ptr_q < wait_len_q) begin
							rd_ptr_q   <= rd_ptr_q + 1'b1;
							ent_vld_s1 <= 1'b1;
						end else begin
							ent_vld_s1 <= 1'b0;
						end
					end
					if (scan_done) begin
						wait_len_q <= keep_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// class lanes with the per-client held table
	mra_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pool_ctl),
		.fit    (fit)
	);

	// wait queue entries: {client, amounts}
	mra_wait_ram #(
		.DEPTH (WAIT_DEPTH),
		.WIDTH (ENTRY_W)
	) u_wait_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (rd_ptr_q[WADDR_W-1:0]),
		.rd_data (ram_rd_data)
	);

	// the queue never grows past its depth
	a_wait_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wait_len_q <= WLEN_W'(WAIT_DEPTH))
		else $error("wait queue length exceeds depth");

	// a scanned entry is only in flight during the scan
	a_entry_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ent_vld_s1 |-> state_q == ST_SCAN)
		else $error("wait entry in flight outside scan");

	// the end of a scan always leaves a last beat in the output register
	a_scan_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_SCAN) |-> (res_valid_q && res_last_q))
		else $error("scan finished without a last beat");

	// compaction never overtakes the read pointer
	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> keep_q <= rd_ptr_q)
		else $error("keep pointer ahead of read pointer");

endmodule
